@@ rtl/toroidal_line_wrap_segmenter_defines.svh @@
// Assertion macros shared by the checker of the line wrap segmenter.
// No dependencies.
`ifndef TOROIDAL_LINE_WRAP_SEGMENTER_DEFINES_SVH
`define TOROIDAL_LINE_WRAP_SEGMENTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TLWS_ASSERT_NOW(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TLWS_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/tlws_pkg.sv @@
// Package of the line wrap segmenter: field widths, constants, register, state and edge codes,
// divider request and response types and the CORDIC arctangent table. No dependencies.
package tlws_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int MAX_SEGMENTS = 16;
  localparam int CFG_W   = 12;
  localparam int POS_W   = 21;
  localparam int ANG_W   = 16;
  localparam int DIST_W  = 24;
  localparam int COORD_W = 20;
  localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS);
  localparam int UNIT_ONE  = 65536;
  localparam int DIR_W   = 18;
  localparam int NUM_W   = COORD_W + 16;
  localparam int TSAT_W  = DIST_W + 1;

  typedef enum logic {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_RIGHT  = 2'd0,
    EDGE_TOP    = 2'd1,
    EDGE_LEFT   = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRAPX, ST_WAITX, ST_WRAPY, ST_WAITY, ST_DIR, ST_WAITD,
    ST_D1, ST_W1, ST_D2, ST_W2, ST_SEL, ST_MX, ST_MY, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    num;
    logic [COORD_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_W-1:0]    quo;
    logic [COORD_W-1:0]  rmd;
  } div_rsp_t;

  function automatic logic signed [23:0] cordic_atan(input logic [3:0] i);
    case (i)
      4'd0:    cordic_atan = 24'sd2097152;
      4'd1:    cordic_atan = 24'sd1238021;
      4'd2:    cordic_atan = 24'sd654136;
      4'd3:    cordic_atan = 24'sd332050;
      4'd4:    cordic_atan = 24'sd166669;
      4'd5:    cordic_atan = 24'sd83416;
      4'd6:    cordic_atan = 24'sd41718;
      4'd7:    cordic_atan = 24'sd20860;
      4'd8:    cordic_atan = 24'sd10430;
      4'd9:    cordic_atan = 24'sd5215;
      4'd10:   cordic_atan = 24'sd2608;
      4'd11:   cordic_atan = 24'sd1304;
      4'd12:   cordic_atan = 24'sd652;
      4'd13:   cordic_atan = 24'sd326;
      4'd14:   cordic_atan = 24'sd163;
      default: cordic_atan = 24'sd81;
    endcase
  endfunction

endpackage

@@ rtl/tlws_ifs.sv @@
// Valid/ready channel interfaces for move commands and emitted segments.
// Depends on tlws_pkg.
interface tlws_cmd_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tlws_pkg::POS_W-1:0]       pos_x;
  logic signed [tlws_pkg::POS_W-1:0]       pos_y;
  logic        [tlws_pkg::ANG_W-1:0]       heading_angle;
  logic        [tlws_pkg::DIST_W-1:0]      move_distance;
  modport source (output valid, pos_x, pos_y, heading_angle, move_distance, input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, move_distance, output ready);
endinterface

interface tlws_seg_if;
  logic                               valid;
  logic                               ready;
  logic [tlws_pkg::COORD_W-1:0]       seg_x0;
  logic [tlws_pkg::COORD_W-1:0]       seg_y0;
  logic [tlws_pkg::COORD_W-1:0]       seg_x1;
  logic [tlws_pkg::COORD_W-1:0]       seg_y1;
  logic [tlws_pkg::DIST_W-1:0]        seg_length;
  logic                               last_segment;
  logic                               truncated;
  modport source (output valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_length, last_segment,
                  truncated, input ready);
  modport sink   (input valid, seg_x0, seg_y0, seg_x1, seg_y1, seg_length, last_segment,
                  truncated, output ready);
endinterface

@@ rtl/toroidal_line_wrap_segmenter.sv @@
// Top level of the toroidal line wrap segmenter: sequencer, segment arithmetic, registers.
// Depends on tlws_pkg, tlws_ifs, tlws_divider and tlws_cordic.
//
// Usage. A move command arrives on the cmd channel (valid/ready): a start position
// relative to the canvas center, a heading and a distance, all Q.8 but the angle.
// Each segment of the wrapped straight move leaves on the seg channel as one item;
// the last item of a move carries last_segment, and truncated when the segment
// limit cut the move short. A zero distance is taken and gives no item.
// The block works on one command at a time: cmd.ready is high only when idle.
// After a command is taken, each start coordinate that lies outside the canvas is
// wrapped by the 36-step divider, then the CORDIC forms the direction (without
// iterating on an axis heading). For each segment the block runs one divider pass per
// reachable candidate edge, picks the edge, forms both products in turn and loads the output.
// A finished segment sits in the output register; while seg.ready is low the block
// holds it and waits. Canvas width and height are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while idle, as the block does not enforce
// it. A zero value counts as one pixel.
// Reset is synchronous: the sequencer returns to idle, no item is pending and the
// canvas returns to 640 by 480 pixels.
module toroidal_line_wrap_segmenter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tlws_pkg::CFG_W-1:0]   cfg_data,
  tlws_cmd_if.sink                     cmd,
  tlws_seg_if.source                   seg
);
  import tlws_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]   canvas_width;
  logic [CFG_W-1:0]   canvas_height;
  logic [COORD_W-1:0] wf;
  logic [COORD_W-1:0] hf;

  // Item registers.
  logic signed [22:0] xs;
  logic signed [22:0] ys;
  logic [ANG_W-1:0]   ang;
  logic [DIST_W-1:0]  rem;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic signed [DIR_W-1:0] dx;
  logic signed [DIR_W-1:0] dy;
  logic [SEG_CNT_W-1:0] n;
  logic [TSAT_W-1:0]  t1;
  logic [TSAT_W-1:0]  t2;
  logic [DIST_W-1:0]  t_cur;
  edge_t              e_cur;
  logic               tail;
  logic [40:0]        prod;
  logic               prod_neg;
  logic [COORD_W-1:0] xm;

  // Output register.
  logic               out_valid;
  logic [COORD_W-1:0] ox0, oy0, ox1, oy1;
  logic [DIST_W-1:0]  olen;
  logic               olast, otrunc;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     dir_start;
  logic     dir_done;
  logic signed [DIR_W-1:0] dir_dx;
  logic signed [DIR_W-1:0] dir_dy;

  edge_t              e1, e2, e_try;
  logic               has_e2;
  logic               hit_ok;
  logic [NUM_W-1:0]   hit_num;
  logic [COORD_W-1:0] hit_den;
  logic [TSAT_W-1:0]  t_sat;
  logic [TSAT_W-1:0]  t_pick;
  logic [DIST_W-1:0]  rem_left;
  logic [COORD_W-1:0] ym;
  logic [DIR_W-1:0]   adx, ady;

  assign wf = {((canvas_width == '0) ? CFG_W'(1) : canvas_width), {FRAC_BITS{1'b0}}};
  assign hf = {((canvas_height == '0) ? CFG_W'(1) : canvas_height), {FRAC_BITS{1'b0}}};
  assign adx = dx[DIR_W-1] ? DIR_W'(-dx) : DIR_W'(dx);
  assign ady = dy[DIR_W-1] ? DIR_W'(-dy) : DIR_W'(dy);

  // Quadrant edges: the clockwise edge first, the next one only inside a quadrant.
  assign e1     = edge_t'(ang[15:14]);
  assign e2     = edge_t'(ang[15:14] + 2'd1);
  assign has_e2 = ang[13:0] != 14'd0;
  assign e_try  = (state == ST_D1) ? e1 : e2;

  // Gap and speed toward the edge under test; the wrong sign never reaches it.
  always_comb begin
    hit_ok  = 1'b0;
    hit_num = '0;
    hit_den = '0;
    case (e_try)
      EDGE_RIGHT: begin
        hit_ok  = !dx[DIR_W-1] && dx != '0;
        hit_num = {COORD_W'(wf - x), 16'h0000};
      end
      EDGE_TOP: begin
        hit_ok  = dy[DIR_W-1];
        hit_num = {y, 16'h0000};
      end
      EDGE_LEFT: begin
        hit_ok  = dx[DIR_W-1];
        hit_num = {x, 16'h0000};
      end
      default: begin
        hit_ok  = !dy[DIR_W-1] && dy != '0;
        hit_num = {COORD_W'(hf - y), 16'h0000};
      end
    endcase
    hit_den = (e_try == EDGE_RIGHT || e_try == EDGE_LEFT) ?
              COORD_W'(adx) : COORD_W'(ady);
  end

  // Distances beyond the distance field saturate; their order then no longer matters.
  assign t_sat = (div_rsp.quo[NUM_W-1:DIST_W] != '0) ? {1'b1, {DIST_W{1'b0}}} :
                 {1'b0, div_rsp.quo[DIST_W-1:0]};
  assign t_pick   = (t2 < t1) ? t2 : t1;
  assign rem_left = rem - t_cur;

  // Coordinate moved by the product in prod, rounded half away from zero, clamped.
  function automatic logic [COORD_W-1:0] move_clamp(input logic [COORD_W-1:0] base,
                                                    input logic [40:0] p,
                                                    input logic neg,
                                                    input logic [COORD_W-1:0] lim);
    logic [40:0]        ps;
    logic signed [26:0] rs;
    logic signed [26:0] v;
    begin
      ps = p + 41'd32768;
      rs = $signed({2'b00, ps[40:16]});
      if (neg) rs = -rs;
      v = $signed({7'b0, base}) + rs;
      if (v[26]) move_clamp = '0;
      else if (v > $signed({7'b0, lim})) move_clamp = lim;
      else move_clamp = v[COORD_W-1:0];
    end
  endfunction

  assign ym = move_clamp(y, prod, prod_neg, hf);

  tlws_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tlws_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (dir_start),
    .angle (ang),
    .done  (dir_done),
    .dx    (dir_dx),
    .dy    (dir_dy)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd.valid && cmd.move_distance != '0) state_next = ST_WRAPX;
      ST_WRAPX: state_next = (xs < 0 || xs > $signed({3'b0, wf})) ? ST_WAITX : ST_WRAPY;
      ST_WAITX: if (div_rsp.done) state_next = ST_WRAPY;
      ST_WRAPY: state_next = (ys < 0 || ys > $signed({3'b0, hf})) ? ST_WAITY : ST_DIR;
      ST_WAITY: if (div_rsp.done) state_next = ST_DIR;
      ST_DIR:   state_next = ST_WAITD;
      ST_WAITD: if (dir_done) state_next = ST_D1;
      ST_D1:    state_next = hit_ok ? ST_W1 : ST_D2;
      ST_W1:    if (div_rsp.done) state_next = ST_D2;
      ST_D2:    state_next = (has_e2 && hit_ok) ? ST_W2 : ST_SEL;
      ST_W2:    if (div_rsp.done) state_next = ST_SEL;
      ST_SEL:   state_next = ST_MX;
      ST_MX:    state_next = ST_MY;
      ST_MY:    state_next = ST_FIN;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (seg.ready) state_next = olast ? ST_IDLE : ST_D1;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd.ready     = 1'b0;
    dir_start     = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = hit_num;
    div_req.den   = hit_den;
    case (state)
      ST_IDLE:  cmd.ready = 1'b1;
      ST_WRAPX: begin
        div_req.start = xs < 0 || xs > $signed({3'b0, wf});
        div_req.num   = NUM_W'(xs[22] ? 23'(-xs) : 23'(xs));
        div_req.den   = wf;
      end
      ST_WRAPY: begin
        div_req.start = ys < 0 || ys > $signed({3'b0, hf});
        div_req.num   = NUM_W'(ys[22] ? 23'(-ys) : 23'(ys));
        div_req.den   = hf;
      end
      ST_DIR:   dir_start = 1'b1;
      ST_D1:    div_req.start = hit_ok;
      ST_D2:    div_req.start = has_e2 && hit_ok;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      canvas_width  <= CFG_W'(640);
      canvas_height <= CFG_W'(480);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == REG_CANVAS_WIDTH) canvas_width <= cfg_data;
        else canvas_height <= cfg_data;
      end
      if (state == ST_FIN) out_valid <= 1'b1;
      else if (state == ST_OUT && seg.ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        xs  <= 23'(cmd.pos_x) + $signed({4'b0, wf[COORD_W-1:1]});
        ys  <= $signed({4'b0, hf[COORD_W-1:1]}) - 23'(cmd.pos_y);
        ang <= cmd.heading_angle;
        rem <= cmd.move_distance;
        n   <= '0;
      end
      ST_WRAPX: x <= xs[COORD_W-1:0];
      ST_WAITX: if (div_rsp.done) begin
        if (!xs[22]) x <= div_rsp.rmd;
        else x <= (div_rsp.rmd == '0) ? '0 : COORD_W'(wf - div_rsp.rmd);
      end
      ST_WRAPY: y <= ys[COORD_W-1:0];
      ST_WAITY: if (div_rsp.done) begin
        if (!ys[22]) y <= div_rsp.rmd;
        else y <= (div_rsp.rmd == '0) ? '0 : COORD_W'(hf - div_rsp.rmd);
      end
      ST_WAITD: if (dir_done) begin
        dx <= dir_dx;
        dy <= dir_dy;
      end
      ST_D1: if (!hit_ok) t1 <= '1;
      ST_W1: if (div_rsp.done) t1 <= t_sat;
      ST_D2: if (!(has_e2 && hit_ok)) t2 <= '1;
      ST_W2: if (div_rsp.done) t2 <= t_sat;
      ST_SEL: begin
        e_cur <= (t2 < t1) ? e2 : e1;
        tail  <= t_pick > {1'b0, rem};
        t_cur <= (t_pick > {1'b0, rem}) ? rem : t_pick[DIST_W-1:0];
      end
      ST_MX: begin
        prod     <= 41'(t_cur) * 41'(adx);
        prod_neg <= dx[DIR_W-1];
      end
      ST_MY: begin
        xm       <= move_clamp(x, prod, prod_neg, wf);
        prod     <= 41'(t_cur) * 41'(ady);
        prod_neg <= dy[DIR_W-1];
      end
      ST_FIN: begin
        ox0    <= x;
        oy0    <= y;
        olen   <= t_cur;
        olast  <= tail || rem_left == '0 || n == SEG_CNT_W'(MAX_SEGMENTS - 1);
        otrunc <= !tail && rem_left != '0 && n == SEG_CNT_W'(MAX_SEGMENTS - 1);
        rem    <= rem_left;
        n      <= n + 1'b1;
        if (tail) begin
          ox1 <= xm;
          oy1 <= ym;
        end else begin
          // Crossing: end on the edge, then jump to the opposite one.
          case (e_cur)
            EDGE_RIGHT: begin
              ox1 <= wf; oy1 <= ym; x <= '0; y <= ym;
            end
            EDGE_TOP: begin
              ox1 <= xm; oy1 <= '0; x <= xm; y <= hf;
            end
            EDGE_LEFT: begin
              ox1 <= '0; oy1 <= ym; x <= wf; y <= ym;
            end
            default: begin
              ox1 <= xm; oy1 <= hf; x <= xm; y <= '0;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  assign seg.valid        = out_valid;
  assign seg.seg_x0       = ox0;
  assign seg.seg_y0       = oy0;
  assign seg.seg_x1       = ox1;
  assign seg.seg_y1       = oy1;
  assign seg.seg_length   = olen;
  assign seg.last_segment = olast;
  assign seg.truncated    = otrunc;
endmodule

@@ rtl/tlws_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tlws_pkg.
module tlws_divider (
  input  logic               clk,
  input  logic               rst,
  input  tlws_pkg::div_req_t req,
  output tlws_pkg::div_rsp_t rsp
);
  import tlws_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [NUM_W-1:0]   q;
  logic [COORD_W-1:0] r;
  logic [COORD_W-1:0] d;
  logic [COORD_W:0]   trial;

  assign trial = {r, q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= req.num;
        d    <= req.den;
        r    <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          r <= COORD_W'(trial - {1'b0, d});
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          r <= trial[COORD_W-1:0];
          q <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = q;
  assign rsp.rmd  = r;
endmodule

@@ rtl/tlws_cordic.sv @@
// Iterative rotation CORDIC giving the canvas direction (y down) of a heading, Q.16.
// Depends on tlws_pkg.
module tlws_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [tlws_pkg::ANG_W-1:0]         angle,
  output logic                               done,
  output logic signed [tlws_pkg::DIR_W-1:0]  dx,
  output logic signed [tlws_pkg::DIR_W-1:0]  dy
);
  import tlws_pkg::*;

  logic               busy;
  logic               fin;
  logic [3:0]         i;
  logic [1:0]         quad;
  logic signed [18:0] cx;
  logic signed [18:0] cy;
  logic signed [23:0] z;
  logic signed [18:0] sx;
  logic signed [18:0] sy;
  logic signed [DIR_W-1:0] c;
  logic signed [DIR_W-1:0] s;

  // Arithmetic shift that truncates toward zero, as the direction table expects.
  function automatic logic signed [18:0] shr_tz(input logic signed [18:0] v,
                                               input logic [3:0] n);
    logic signed [18:0] m;
    begin
      m = -v;
      shr_tz = v[18] ? -(m >>> n) : (v >>> n);
    end
  endfunction

  function automatic logic signed [DIR_W-1:0] sat1(input logic signed [18:0] v);
    if (v > 19'sd65536) sat1 = 18'sd65536;
    else if (v < -19'sd65536) sat1 = -18'sd65536;
    else sat1 = v[DIR_W-1:0];
  endfunction

  assign sx = shr_tz(cx, i);
  assign sy = shr_tz(cy, i);
  assign c  = sat1(cx);
  assign s  = sat1(cy);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quad <= angle[15:14];
        i    <= '0;
        if (angle[13:0] == 14'd0) begin
          cx  <= 19'sd65536;
          cy  <= 19'sd0;
          fin <= 1'b1;
        end else begin
          cx   <= 19'sd39797;
          cy   <= 19'sd0;
          z    <= $signed({2'b00, angle[13:0], 8'h00});
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!z[23]) begin
          cx <= cx - sy;
          cy <= cy + sx;
          z  <= z - cordic_atan(i);
        end else begin
          cx <= cx + sy;
          cy <= cy - sx;
          z  <= z + cordic_atan(i);
        end
        i <= i + 1'b1;
        if (i == 4'd15) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        case (quad)
          EDGE_RIGHT: begin dx <= c;  dy <= -s; end
          EDGE_TOP:   begin dx <= -s; dy <= -c; end
          EDGE_LEFT:  begin dx <= -c; dy <= s;  end
          default:    begin dx <= s;  dy <= c;  end
        endcase
      end
    end
  end
endmodule

@@ rtl/tlws_checker.sv @@
// Port-level checker of the line wrap segmenter and its bind to the top level.
// Depends on tlws_pkg and toroidal_line_wrap_segmenter_defines.svh.
`include "toroidal_line_wrap_segmenter_defines.svh"
module tlws_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic [tlws_pkg::DIST_W-1:0] move_distance,
  input logic                        seg_valid,
  input logic                        seg_ready,
  input logic                        last_segment,
  input logic                        truncated
);
  import tlws_pkg::*;

  // A command is never taken while a segment is still on offer.
  `TLWS_ASSERT_NOW(a_busy_excl, clk, rst, cmd_ready, !seg_valid, "ready while segment pending")
  // Truncation is reported only on the final segment.
  `TLWS_ASSERT_NOW(a_trunc_last, clk, rst, seg_valid && truncated, last_segment,
    "truncated without last_segment")
  // A command with distance keeps the block busy.
  `TLWS_ASSERT_NEXT(a_cmd_busy, clk, rst, cmd_valid && cmd_ready && move_distance != '0,
    !cmd_ready, "ready right after a move was accepted")
  // After a segment that is not the last is taken, the block stays busy.
  `TLWS_ASSERT_NEXT(a_more_segs, clk, rst, seg_valid && seg_ready && !last_segment,
    !cmd_ready, "ready before the final segment")
endmodule

bind toroidal_line_wrap_segmenter tlws_checker u_tlws_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .move_distance (cmd.move_distance),
  .seg_valid     (seg.valid),
  .seg_ready     (seg.ready),
  .last_segment  (seg.last_segment),
  .truncated     (seg.truncated)
);
